>>> sv/stream_replace_first_match_assert.svh
// Assertion helpers shared by the stream editor modules.
// The clock is clk and the asynchronous reset is arst_n in every user.
`ifndef STREAM_REPLACE_FIRST_MATCH_ASSERT_SVH
`define STREAM_REPLACE_FIRST_MATCH_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every rising edge outside reset.
`define SRFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SRFM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define SRFM_ASSERT(lbl, prop, msg)
`define SRFM_NEVER(lbl, cond, msg)

`endif

`endif

>>> sv/srfm_pkg.sv
package srfm_pkg;

	// Fixed sizes of the register file and of the result counters
	localparam int REPL_MAX = 8;
	localparam int REG_W    = 64;
	localparam int CNT_W    = 4;
	localparam int POS_W    = 5;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} reg_index_t;

	// One input beat
	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       line_end;
	} in_item_t;

	// One output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_present;
		logic       out_line_end;
		logic       run_last;
	} out_item_t;

	// Result list of one item: replacement before, window bytes, replacement after
	typedef struct packed {
		logic [CNT_W-1:0] pre_n;
		logic [CNT_W-1:0] e_n;
		logic [POS_W-1:0] total;
		logic             empty;
		logic             line_end;
	} job_ctl_t;

endpackage

>>> sv/srfm_window.sv
`include "stream_replace_first_match_assert.svh"

module srfm_window
	import srfm_pkg::*;
#(
	parameter int PMAX = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  in_item_t               item,
	input  logic                   take,
	input  logic [REG_W-1:0]       pattern_bytes,
	input  logic [CNT_W-1:0]       pattern_length,
	input  logic [CNT_W-1:0]       replacement_length,
	output logic                   job_has,
	output job_ctl_t               job,
	output logic [PMAX:0][7:0]     ext
);

	localparam int FW = $clog2(PMAX + 1);
	localparam int EW = $clog2(PMAX + 1);

	logic [7:0]       window_q [PMAX];
	logic [FW-1:0]    fill_q;
	logic             replaced_q;
	logic             started_q;

	logic [7:0]       pat [PMAX];
	logic [7:0]       win_d [PMAX];
	logic [CNT_W-1:0] plen;
	logic [CNT_W-1:0] rlen;
	logic [CNT_W-1:0] fill_c;
	logic [CNT_W-1:0] len_ext;
	logic [CNT_W-1:0] first_s;
	logic [CNT_W-1:0] d;
	logic [CNT_W-1:0] m;
	logic [CNT_W-1:0] m_fin;
	logic [CNT_W:0]   idx;
	logic             pre_ok;
	logic             ok;
	logic             ignored;
	logic             ins_pre;
	logic             rep;
	logic             match;
	logic             shift_en;
	logic [CNT_W-1:0] e_n;
	logic [CNT_W-1:0] pre_n;
	logic [CNT_W-1:0] post_n;
	logic [POS_W-1:0] total;
	logic [FW-1:0]    fill_d;
	logic             replaced_d;
	logic             started_d;

	// Extend the window by the new byte and find how many bytes must leave
	always_comb begin
		plen = (pattern_length > CNT_W'(PMAX)) ? CNT_W'(PMAX) : pattern_length;
		rlen = (replacement_length > CNT_W'(REPL_MAX)) ? CNT_W'(REPL_MAX)
			: replacement_length;
		for (int i = 0; i < PMAX; i++) begin
			pat[i] = pattern_bytes[8*i +: 8];
		end
		fill_c  = CNT_W'(fill_q);
		len_ext = fill_c + CNT_W'(1);
		for (int j = 0; j < PMAX; j++) begin
			ext[j] = (CNT_W'(j) == fill_c) ? item.text_byte : window_q[j];
		end
		ext[PMAX] = item.text_byte;
		first_s = (fill_c == CNT_W'(PMAX)) ? CNT_W'(1) : CNT_W'(0);
		d = len_ext;
		m = '0;
		pre_ok = 1'b1;
		ok = 1'b0;
		for (int s = PMAX; s >= 0; s--) begin
			m = len_ext - CNT_W'(s);
			pre_ok = 1'b1;
			for (int i = 0; (i + s <= PMAX) && (i < PMAX); i++) begin
				if (CNT_W'(i) < m && ext[s+i] != pat[i]) begin
					pre_ok = 1'b0;
				end
			end
			ok = (CNT_W'(s) <= len_ext) && ((m == '0) ||
				((m <= plen) && pre_ok && !((m == plen) && (s != 0))));
			if (ok && CNT_W'(s) >= first_s) begin
				d = CNT_W'(s);
			end
		end
		m_fin = len_ext - d;
	end

	// Decide the result list and the next per-line state
	always_comb begin
		ignored  = !item.byte_present && !item.line_end;
		ins_pre  = !replaced_q && (plen == '0) && !started_q;
		rep      = replaced_q || ins_pre;
		match    = item.byte_present && !rep && (plen != '0) && (m_fin == plen);
		shift_en = 1'b0;
		fill_d   = fill_q;
		if (!item.byte_present) begin
			e_n = fill_c;
		end else if (rep) begin
			e_n = len_ext;
		end else if (match) begin
			e_n    = '0;
			fill_d = '0;
		end else begin
			e_n      = item.line_end ? len_ext : d;
			shift_en = !item.line_end;
			fill_d   = FW'(m_fin);
		end
		if (item.line_end || (item.byte_present && rep)) begin
			fill_d = '0;
		end
		pre_n  = ins_pre ? rlen : '0;
		post_n = match ? rlen : '0;
		total  = POS_W'(pre_n) + POS_W'(e_n) + POS_W'(post_n);
		replaced_d = item.line_end ? 1'b0 : (replaced_q || ins_pre || match);
		started_d  = item.line_end ? 1'b0 : (started_q || item.byte_present);
		job_has    = !ignored && ((total != '0) || item.line_end);
		job.pre_n    = pre_n;
		job.e_n      = e_n;
		job.total    = total;
		job.empty    = (total == '0);
		job.line_end = item.line_end;
	end

	// Shift the surviving bytes down to the window head
	always_comb begin
		idx = '0;
		for (int j = 0; j < PMAX; j++) begin
			idx = (CNT_W+1)'(d) + (CNT_W+1)'(j);
			win_d[j] = (idx <= (CNT_W+1)'(PMAX)) ? ext[idx[EW-1:0]] : window_q[j];
		end
	end

	// Hold per-line control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			replaced_q <= 1'b0;
			started_q  <= 1'b0;
		end else if (take && !ignored) begin
			fill_q     <= fill_d;
			replaced_q <= replaced_d;
			started_q  <= started_d;
		end
	end

	// Advance the window bytes
	always_ff @(posedge clk) begin
		if (take && !ignored && shift_en) begin
			for (int j = 0; j < PMAX; j++) begin
				window_q[j] <= win_d[j];
			end
		end
	end

	`SRFM_NEVER(a_fill_range, fill_q > FW'(PMAX), "window fill beyond pattern size")
	`SRFM_ASSERT(a_replaced_empty, replaced_q |-> (fill_q == '0), "window held after replace")
	`SRFM_ASSERT(a_line_end_clear, (take && item.line_end) |=> (fill_q == '0 && !started_q && !replaced_q), "line state kept after line end")

endmodule

>>> sv/srfm_emit.sv
`include "stream_replace_first_match_assert.svh"

module srfm_emit
	import srfm_pkg::*;
#(
	parameter int PMAX = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   job_load,
	input  job_ctl_t               job,
	input  logic [PMAX:0][7:0]     ext,
	input  logic [REG_W-1:0]       replacement_bytes,
	output logic                   can_load,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data
);

	localparam int EW = $clog2(PMAX + 1);

	logic                 job_v_q;
	logic [POS_W-1:0]     pos_q;
	job_ctl_t             ctl_s2;
	logic [PMAX:0][7:0]   ext_s2;

	logic                 last;
	logic [POS_W-1:0]     a;
	logic [POS_W-1:0]     ae;
	logic [POS_W-1:0]     k;
	logic [7:0]           sel_byte;

	// Pick the byte at the current position of the result list
	always_comb begin
		a  = POS_W'(ctl_s2.pre_n);
		ae = a + POS_W'(ctl_s2.e_n);
		k  = '0;
		if (pos_q < a) begin
			sel_byte = replacement_bytes[8*pos_q[2:0] +: 8];
		end else if (pos_q < ae) begin
			k        = pos_q - a;
			sel_byte = ext_s2[k[EW-1:0]];
		end else begin
			k        = pos_q - ae;
			sel_byte = replacement_bytes[8*k[2:0] +: 8];
		end
		last     = ctl_s2.empty || (pos_q == ctl_s2.total - POS_W'(1));
		can_load = !job_v_q || (out_ready && last);
	end

	// Drive the output beat
	always_comb begin
		out_valid             = job_v_q;
		out_data.out_byte     = ctl_s2.empty ? 8'd0 : sel_byte;
		out_data.out_present  = !ctl_s2.empty;
		out_data.out_line_end = ctl_s2.line_end && last;
		out_data.run_last     = last;
	end

	// Load a new result list or step through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_q <= 1'b0;
			pos_q   <= '0;
		end else if (can_load) begin
			job_v_q <= job_load;
			pos_q   <= '0;
		end else if (out_ready) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	// Capture the result list payload
	always_ff @(posedge clk) begin
		if (can_load && job_load) begin
			ctl_s2 <= job;
			ext_s2 <= ext;
		end
	end

	`SRFM_ASSERT(a_pos_range, job_v_q |-> (ctl_s2.empty ? (pos_q == '0) : (pos_q < ctl_s2.total)), "result position out of range")
	`SRFM_ASSERT(a_pos_hold, (job_v_q && !out_ready) |=> $stable(pos_q), "position moved while stalled")
	`SRFM_ASSERT(a_more_beats, (job_v_q && out_ready && !last) |=> job_v_q, "result list cut short")

endmodule

>>> sv/stream_replace_first_match.sv
// Streaming editor that replaces the first occurrence of a pattern in a line.
// Input beats (in_valid/in_ready, in_data) carry one text byte each, or an
// empty line end; output beats (out_valid/out_ready, out_data) carry the
// edited line, with run_last on the final beat caused by one input beat.
// Configuration: cfg_we writes cfg_data into register cfg_index at once:
// 0 pattern bytes, 1 pattern length, 2 replacement bytes, 3 replacement length.
// Write registers only while no beat is in flight.
// Timing: an input beat is registered, then its results are computed in one
// pass into a result register, from which the output beat is presented.
// Throughput is one input beat per cycle while each beat yields at most one
// result and the receiver does not stall; a beat that yields several results
// holds the output register until each has been taken, one per output beat,
// at the single output port.
// Beats held in the match window produce no result until they leave it.
// Reset clears the registers to zero and the per-line state; the window
// needs no clearing pass. When the receiver stalls, the result register
// holds, the input register fills, and in_ready falls.
module stream_replace_first_match
	import srfm_pkg::*;
#(
	parameter int PATTERN_MAX_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	logic [REG_W-1:0]               pattern_bytes_q;
	logic [CNT_W-1:0]               pattern_length_q;
	logic [REG_W-1:0]               replacement_bytes_q;
	logic [CNT_W-1:0]               replacement_length_q;

	logic                           in_v_s1;
	in_item_t                       in_s1;
	logic                           can_load;
	logic                           take;
	logic                           job_has;
	job_ctl_t                       job;
	logic [PATTERN_MAX_BYTES:0][7:0] ext;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= '0;
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data;
				REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data[CNT_W-1:0];
				REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data;
				REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Hand the registered beat to the window when the result stage frees up
	assign take     = in_v_s1 && can_load;
	assign in_ready = !in_v_s1 || can_load;

	// Hold the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (in_ready) begin
			in_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_s1 <= in_data;
		end
	end

	srfm_window #(
		.PMAX(PATTERN_MAX_BYTES)
	) u_window (
		.clk                (clk),
		.arst_n             (arst_n),
		.item               (in_s1),
		.take               (take),
		.pattern_bytes      (pattern_bytes_q),
		.pattern_length     (pattern_length_q),
		.replacement_length (replacement_length_q),
		.job_has            (job_has),
		.job                (job),
		.ext                (ext)
	);

	srfm_emit #(
		.PMAX(PATTERN_MAX_BYTES)
	) u_emit (
		.clk               (clk),
		.arst_n            (arst_n),
		.job_load          (take && job_has),
		.job               (job),
		.ext               (ext),
		.replacement_bytes (replacement_bytes_q),
		.can_load          (can_load),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.out_data          (out_data)
	);

endmodule
